### hw/rtl/websocket_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Modules include this header and expect a clock named clock and a reset named reset.
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define WSFR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define WSFR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define WSFR_ASSERT(lbl, prop, msg)
`define WSFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/wsfr_pkg.sv
// Shared types and constants of the frame receiver.
// No dependencies; used by the parser, the result buffer and the top level.
package wsfr_pkg;

   // Frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;

   // Result kinds
   localparam logic [2:0] KIND_MSG         = 3'd0;
   localparam logic [2:0] KIND_PING        = 3'd1;
   localparam logic [2:0] KIND_CLOSE       = 3'd2;
   localparam logic [2:0] KIND_EMPTY_DATA  = 3'd3;
   localparam logic [2:0] KIND_EMPTY_PING  = 3'd4;
   localparam logic [2:0] KIND_EMPTY_CLOSE = 3'd5;
   localparam logic [2:0] KIND_ERROR       = 3'd6;

   // Header encoding
   localparam logic [6:0]  LEN16_CODE    = 7'd126;
   localparam logic [6:0]  LEN64_CODE    = 7'd127;
   localparam logic [63:0] CTRL_MAX_LEN  = 64'd125;
   localparam logic [3:0]  EXT16_BYTES   = 4'd2;
   localparam logic [3:0]  EXT64_BYTES   = 4'd8;
   localparam logic [3:0]  MASK_BYTES    = 4'd4;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'h0001_0000;

   // One result beat
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       is_binary;
      logic       end_of_frame;
      logic       end_of_message;
   } wsfr_result_type;

endpackage

### hw/rtl/wsfr_parser.sv
// Input register and frame parser: header decode, checks and payload unmasking.
// Depends on wsfr_pkg and the assertion macros header.
`include "websocket_frame_receiver_defines.svh"

module wsfr_parser import wsfr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,
   input  logic [31:0]     max_payload,
   input  logic            buf_full,
   output logic            push,
   output wsfr_result_type result
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_MASK    = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [7:0]  byte_ff;
   logic        byte_vld_ff;
   logic        advance;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  mask_idx_ff, mask_idx_in;
   logic        frag_ff, frag_in;
   logic        binary_ff, binary_in;
   logic        halted_ff, halted_in;

   logic        hdr_done;
   logic [63:0] len_chk;
   logic [3:0]  count_dec;
   logic        bad;
   logic        is_data;
   logic [7:0]  key_byte;
   logic        last;
   logic        res_vld;
   logic [2:0]  res_kind;
   logic [7:0]  res_data;
   logic        res_eof;
   logic        res_eom;

   // Hold one byte; take the next one as this one moves on
   assign advance    = byte_vld_ff && !buf_full;
   assign req_tready = !byte_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         byte_vld_ff <= 1'b1;
      end else if (advance) begin
         byte_vld_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   assign count_dec = count_ff - 4'd1;
   assign is_data   = (opcode_ff == OP_CONT) || (opcode_ff == OP_TEXT) ||
                      (opcode_ff == OP_BINARY);

   // Select the key byte for this payload position
   always_comb begin
      case (mask_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Decode the held byte against the frame state
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      mask_idx_in  = mask_idx_ff;
      frag_in      = frag_ff;
      binary_in    = binary_ff;
      halted_in    = halted_ff;
      hdr_done     = 1'b0;
      len_chk      = length_ff;
      bad          = 1'b0;
      last         = 1'b0;
      res_vld      = 1'b0;
      res_kind     = KIND_MSG;
      res_data     = 8'd0;
      res_eof      = 1'b0;
      res_eom      = 1'b0;

      if (!halted_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = byte_ff[7];
               opcode_in = byte_ff[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = byte_ff[7];
               key_in    = 32'd0;
               if (byte_ff[6:0] == LEN16_CODE || byte_ff[6:0] == LEN64_CODE) begin
                  length_in = 64'd0;
                  count_in  = (byte_ff[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in  = PH_EXTLEN;
               end else begin
                  length_in = {57'd0, byte_ff[6:0]};
                  if (byte_ff[7]) begin
                     count_in = MASK_BYTES;
                     phase_in = PH_MASK;
                  end else begin
                     hdr_done = 1'b1;
                     len_chk  = {57'd0, byte_ff[6:0]};
                  end
               end
            end
            PH_EXTLEN: begin
               length_in = {length_ff[55:0], byte_ff};
               count_in  = count_dec;
               if (count_dec == 4'd0) begin
                  if (masked_ff) begin
                     count_in = MASK_BYTES;
                     phase_in = PH_MASK;
                  end else begin
                     hdr_done = 1'b1;
                     len_chk  = {length_ff[55:0], byte_ff};
                  end
               end
            end
            PH_MASK: begin
               key_in   = {key_ff[23:0], byte_ff};
               count_in = count_dec;
               if (count_dec == 4'd0) begin
                  hdr_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               mask_idx_in  = mask_idx_ff + 2'd1;
               remaining_in = remaining_ff - 32'd1;
               last         = (remaining_in == 32'd0);
               res_data     = byte_ff ^ (masked_ff ? key_byte : 8'd0);
               res_eof      = last;
               if (last) begin
                  phase_in = PH_HDR0;
               end
               if (is_data) begin
                  res_vld  = 1'b1;
                  res_kind = KIND_MSG;
                  res_eom  = last && fin_ff;
               end else if (opcode_ff == OP_PING) begin
                  res_vld  = 1'b1;
                  res_kind = KIND_PING;
               end else if (opcode_ff == OP_CLOSE) begin
                  res_vld  = 1'b1;
                  res_kind = KIND_CLOSE;
                  if (last) begin
                     halted_in = 1'b1;
                  end
               end else begin
                  // Drop pong payload
                  res_data = 8'd0;
                  res_eof  = 1'b0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase

         // Check the complete header and start the payload
         if (hdr_done) begin
            bad = (len_chk[63:32] != 32'd0) || (len_chk[31:0] > max_payload);
            if (opcode_ff[3] && (!fin_ff || len_chk > CTRL_MAX_LEN)) begin
               bad = 1'b1;
            end
            if (opcode_ff inside {[4'h3:4'h7], [4'hB:4'hF]}) begin
               bad = 1'b1;
            end
            if (opcode_ff == OP_CONT && !frag_ff) begin
               bad = 1'b1;
            end
            if ((opcode_ff == OP_TEXT || opcode_ff == OP_BINARY) && frag_ff) begin
               bad = 1'b1;
            end

            if (bad) begin
               halted_in = 1'b1;
               phase_in  = PH_HDR0;
               res_vld   = 1'b1;
               res_kind  = KIND_ERROR;
            end else begin
               if (opcode_ff == OP_TEXT || opcode_ff == OP_BINARY) begin
                  binary_in = (opcode_ff == OP_BINARY);
               end
               if (is_data) begin
                  frag_in = !fin_ff;
               end
               remaining_in = len_chk[31:0];
               mask_idx_in  = 2'd0;
               if (len_chk[31:0] != 32'd0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  phase_in = PH_HDR0;
                  res_eof  = 1'b1;
                  if (is_data) begin
                     res_vld  = 1'b1;
                     res_kind = KIND_EMPTY_DATA;
                     res_eom  = fin_ff;
                  end else if (opcode_ff == OP_PING) begin
                     res_vld  = 1'b1;
                     res_kind = KIND_EMPTY_PING;
                  end else if (opcode_ff == OP_CLOSE) begin
                     res_vld   = 1'b1;
                     res_kind  = KIND_EMPTY_CLOSE;
                     halted_in = 1'b1;
                  end else begin
                     res_eof = 1'b0;
                  end
               end
            end
         end
      end
   end

   assign push                  = advance && res_vld;
   assign result.kind           = res_kind;
   assign result.data           = res_data;
   assign result.is_binary      = binary_in;
   assign result.end_of_frame   = res_eof;
   assign result.end_of_message = res_eom;

   // Advance the frame state once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         count_ff     <= 4'd0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'd0;
         masked_ff    <= 1'b0;
         length_ff    <= 64'd0;
         remaining_ff <= 32'd0;
         key_ff       <= 32'd0;
         mask_idx_ff  <= 2'd0;
         frag_ff      <= 1'b0;
         binary_ff    <= 1'b0;
         halted_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         masked_ff    <= masked_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         mask_idx_ff  <= mask_idx_in;
         frag_ff      <= frag_in;
         binary_ff    <= binary_in;
         halted_ff    <= halted_in;
      end
   end

   `WSFR_ASSERT(a_halt_silent, halted_ff |-> !push, "result pushed while halted")
   `WSFR_ASSERT(a_error_halts, (push && result.kind == KIND_ERROR) |=> halted_ff,
                "error result did not halt the parser")

endmodule

### hw/rtl/wsfr_out_buf.sv
// Two-entry result buffer: an output register and a skid register behind it.
// Depends on wsfr_pkg and the assertion macros header.
`include "websocket_frame_receiver_defines.svh"

module wsfr_out_buf import wsfr_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  wsfr_result_type push_data,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output wsfr_result_type rsp_data
);

   logic            out_vld_ff;
   logic            skid_vld_ff;
   wsfr_result_type out_ff;
   wsfr_result_type skid_ff;
   logic            pop;

   assign pop       = out_vld_ff && rsp_ready;
   assign full      = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Control: move the skid beat forward first, else take the pushed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            out_ff <= push_data;
         end
      end
   end

   `WSFR_ASSERT_ALWAYS(a_skid_behind_out, skid_vld_ff |-> out_vld_ff,
                       "skid entry held with empty output register")
   `WSFR_ASSERT(a_no_push_full, push |-> !skid_vld_ff, "beat pushed into full buffer")

endmodule

### hw/rtl/websocket_frame_receiver.sv
// WebSocket frame receiver, top level: config register, parser and result buffer.
// Depends on wsfr_pkg, wsfr_parser and wsfr_out_buf.
//
// Takes the received byte stream after the opening handshake, one byte per beat,
// and sustains one byte per clock while the result buffer is not full. Each byte
// passes an input register, is decoded and unmasked by the parser, and lands in
// a two-entry result buffer: a result goes from the input register to the output
// register, and the skid register holds one more while rsp_tready is low. Header
// bytes give a result only when they end an empty frame or reveal an error. Message,
// ping and close bytes stream out as they arrive. After a close frame or a protocol
// error the block consumes and drops all input until reset. There is no clearing
// pass after reset. Write max_payload (csr_wr_en/csr_wr_data) only while idle.
module websocket_frame_receiver import wsfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] data, [8] end_of_message, [15:9] zero
   output logic [3:0]  rsp_tuser,    // [2:0] kind, [3] is_binary
   output logic        rsp_tlast,    // end_of_frame
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data   // max_payload
);

   logic [31:0]     max_payload_ff;
   logic            buf_full;
   logic            push;
   wsfr_result_type parsed;
   wsfr_result_type rsp_res;

   // Hold the payload length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   wsfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .max_payload (max_payload_ff),
      .buf_full    (buf_full),
      .push        (push),
      .result      (parsed)
   );

   wsfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (parsed),
      .full      (buf_full),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_res)
   );

   // Pack the result beat
   assign rsp_tdata = {7'd0, rsp_res.end_of_message, rsp_res.data};
   assign rsp_tuser = {rsp_res.is_binary, rsp_res.kind};
   assign rsp_tlast = rsp_res.end_of_frame;

endmodule
